[design/framed_packet_receiver_crc16_top_defines.svh]
// Assertion macros for the checker file.
`ifndef FRAMED_PACKET_RECEIVER_CRC16_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_TOP_DEFINES_SVH

// Checked only while out of reset.
`define FPRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define FPRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/fprc_pkg.sv]
`timescale 1ns / 1ps
package fprc_pkg;

  localparam int unsigned MaxPacketDef = 64;
  localparam int unsigned TotW = 17;

  localparam logic [7:0] Hdr0 = 8'hFF;
  localparam logic [7:0] Hdr1 = 8'hFE;
  localparam logic [7:0] Hdr2 = 8'hFD;
  localparam logic [15:0] CrcPoly = 16'h8005;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_HEADER  = 3'd1,
    ST_RECV    = 3'd2,
    ST_OK      = 3'd3,
    ST_CRC_ERR = 3'd4,
    ST_LEN_ERR = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_BODY_RD,
    S_BODY_EM,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_FIN
  } state_e;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = Hdr0;
      2'd1: r = Hdr1;
      default: r = Hdr2;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/fprc_store.sv]
`timescale 1ns / 1ps
module fprc_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/framed_packet_receiver_crc16_top.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// rx      | in        | rx_valid_i, rx_stall_o | rx_byte_i
// out     | out       | out_valid_o, out_stall_i | status_o, body_byte_o, body_valid_o, body_last_o
// A plain byte is accepted (S_IDLE), processed (S_PROC) and gives one result transaction (S_FIN).
// Each replayed byte is first read from the packet store (S_RD). The store has a single read port,
// so a good packet emits each body byte after its own read (S_BODY_RD, S_BODY_EM), and a resync
// search reads each stored byte before it checks it (S_SRCH_RD, S_SRCH_CHK).
// Reset is asynchronous and clears all control state; the store needs no clearing.
// A stall on the output holds the sequencer in its process and emit states until the result is taken.
module framed_packet_receiver_crc16_top #(
  parameter int unsigned MaxPacket = fprc_pkg::MaxPacketDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] body_byte_o,
  output logic       body_valid_o,
  output logic       body_last_o
);
  import fprc_pkg::*;

  localparam int unsigned AW = $clog2(MaxPacket);
  localparam int unsigned CW = $clog2(MaxPacket + 1);
  localparam logic [CW:0] MaxW = (CW + 1)'(MaxPacket);
  localparam logic [TotW-1:0] MaxT = TotW'(MaxPacket);

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= MaxW) ? (s - MaxW) : s;
    return r[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] c_q, c_d, replay_q, replay_d, idx_q, idx_d, live_q, live_d, t_q, t_d;
  logic [AW-1:0] base_q, base_d;
  logic hs_q, hs_d, src_mem_q, src_mem_d, emitted_q, emitted_d;
  logic [TotW-1:0] total_q, total_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0] lenlo_q, lenlo_d, prev_q, prev_d, b_q, b_d, w0_q, w0_d, w1_q, w1_d;
  status_e last_q, last_d;
  logic ov_q, ov_d, obv_q, obv_d, obl_q, obl_d;
  logic [2:0] ost_q, ost_d;
  logic [7:0] obyte_q, obyte_d;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] rdata;

  logic can_push, push, push_v, push_l, go_next, drop;
  status_e push_st;
  logic [7:0] push_byte, b;
  logic [CW-1:0] c1, nr, live_now;
  logic [CW:0] drop_n;
  logic [TotW-1:0] tot_new;
  logic [15:0] len;

  fprc_store #(.Depth(MaxPacket), .AddrW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      c_q       <= '0;
      replay_q  <= '0;
      base_q    <= '0;
      hs_q      <= 1'b0;
      total_q   <= '0;
      crc_q     <= '0;
      emitted_q <= 1'b0;
      last_q    <= ST_HUNT;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      c_q       <= c_d;
      replay_q  <= replay_d;
      base_q    <= base_d;
      hs_q      <= hs_d;
      total_q   <= total_d;
      crc_q     <= crc_d;
      emitted_q <= emitted_d;
      last_q    <= last_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    live_q    <= live_d;
    t_q       <= t_d;
    src_mem_q <= src_mem_d;
    lenlo_q   <= lenlo_d;
    prev_q    <= prev_d;
    b_q       <= b_d;
    w0_q      <= w0_d;
    w1_q      <= w1_d;
    ost_q     <= ost_d;
    obyte_q   <= obyte_d;
    obv_q     <= obv_d;
    obl_q     <= obl_d;
  end

  always_comb begin
    state_d = state_q;
    c_d = c_q;
    replay_d = replay_q;
    base_d = base_q;
    hs_d = hs_q;
    total_d = total_q;
    crc_d = crc_q;
    emitted_d = emitted_q;
    last_d = last_q;
    idx_d = idx_q;
    live_d = live_q;
    t_d = t_q;
    src_mem_d = src_mem_q;
    lenlo_d = lenlo_q;
    prev_d = prev_q;
    b_d = b_q;
    w0_d = w0_q;
    w1_d = w1_q;
    ov_d = ov_q && out_stall_i;
    ost_d = ost_q;
    obyte_d = obyte_q;
    obv_d = obv_q;
    obl_d = obl_q;
    we = 1'b0;
    re = 1'b0;
    waddr = wrap((CW + 1)'(base_q) + (CW + 1)'(c_q));
    raddr = wrap((CW + 1)'(base_q) + (CW + 1)'(c_q));
    can_push = !ov_q || !out_stall_i;
    push = 1'b0;
    push_st = ST_HUNT;
    push_byte = '0;
    push_v = 1'b0;
    push_l = 1'b0;
    go_next = 1'b0;
    drop = 1'b0;
    drop_n = '0;
    nr = replay_q;
    b = src_mem_q ? rdata : b_q;
    c1 = c_q + CW'(1);
    live_now = c1 + replay_q;
    len = {b, lenlo_q};
    tot_new = TotW'(len) + TotW'(5);

    unique case (state_q)
      S_IDLE: begin
        if (rx_valid_i) begin
          we = 1'b1;
          b_d = rx_byte_i;
          src_mem_d = 1'b0;
          emitted_d = 1'b0;
          last_d = ST_HUNT;
          state_d = S_PROC;
        end
      end
      S_RD: begin
        re = 1'b1;
        replay_d = replay_q - CW'(1);
        src_mem_d = 1'b1;
        state_d = S_PROC;
      end
      S_PROC: begin
        if (can_push) begin
          go_next = 1'b1;
          if (!hs_q) begin
            if (c_q < CW'(3) && b == hdr_byte(c_q[1:0])) begin
              c_d = c1;
              crc_d = crc16_step(crc_q, b);
              if (c1 == CW'(3)) begin
                hs_d = 1'b1;
                last_d = ST_HEADER;
              end else begin
                last_d = ST_HUNT;
              end
            end else begin
              drop = 1'b1;
              drop_n = (CW + 1)'(1);
              nr = c_q + replay_q;
              last_d = ST_HUNT;
            end
          end else begin
            c_d = c1;
            prev_d = b;
            if (c1 <= CW'(5) || TotW'(c_q) + TotW'(2) < total_q) begin
              crc_d = crc16_step(crc_q, b);
            end
            if (c1 < CW'(5)) begin
              if (c_q == CW'(3)) begin
                lenlo_d = b;
              end
              last_d = ST_RECV;
            end else if (c1 == CW'(5)) begin
              total_d = tot_new;
              if (len < 16'd2 || tot_new > MaxT) begin
                push = 1'b1;
                push_st = ST_LEN_ERR;
                drop = 1'b1;
                drop_n = (CW + 1)'(1);
                nr = c_q + replay_q;
              end else begin
                last_d = ST_RECV;
              end
            end else if (TotW'(c1) >= total_q) begin
              if ({b, prev_q} == crc_q) begin
                if (c1 <= CW'(7)) begin
                  push = 1'b1;
                  push_st = ST_OK;
                  drop = 1'b1;
                  drop_n = (CW + 1)'(c1);
                end else begin
                  go_next = 1'b0;
                  t_d = c1;
                  idx_d = CW'(5);
                  state_d = S_BODY_RD;
                end
              end else begin
                push = 1'b1;
                push_st = ST_CRC_ERR;
                live_d = live_now;
                if (live_now >= CW'(10)) begin
                  go_next = 1'b0;
                  idx_d = CW'(3);
                  state_d = S_SRCH_RD;
                end else begin
                  drop = 1'b1;
                  drop_n = (CW + 1)'(live_now);
                  nr = '0;
                end
              end
            end else begin
              last_d = ST_RECV;
            end
          end
        end
      end
      S_BODY_RD: begin
        re = 1'b1;
        raddr = wrap((CW + 1)'(base_q) + (CW + 1)'(idx_q));
        state_d = S_BODY_EM;
      end
      S_BODY_EM: begin
        if (can_push) begin
          push = 1'b1;
          push_st = ST_OK;
          push_byte = rdata;
          push_v = 1'b1;
          push_l = (idx_q == t_q - CW'(3));
          if (push_l) begin
            go_next = 1'b1;
            drop = 1'b1;
            drop_n = (CW + 1)'(t_q);
          end else begin
            idx_d = idx_q + CW'(1);
            state_d = S_BODY_RD;
          end
        end
      end
      S_SRCH_RD: begin
        re = 1'b1;
        raddr = wrap((CW + 1)'(base_q) + (CW + 1)'(idx_q));
        state_d = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (idx_q >= CW'(5) && w1_q == Hdr0 && w0_q == Hdr1 && rdata == Hdr2) begin
          go_next = 1'b1;
          drop = 1'b1;
          drop_n = (CW + 1)'(idx_q - CW'(2));
          nr = live_q - (idx_q - CW'(2));
        end else if ((CW + 1)'(idx_q) + (CW + 1)'(6) > (CW + 1)'(live_q)) begin
          go_next = 1'b1;
          drop = 1'b1;
          drop_n = (CW + 1)'(live_q);
          nr = '0;
        end else begin
          w1_d = w0_q;
          w0_d = rdata;
          idx_d = idx_q + CW'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_FIN: begin
        if (emitted_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          push = 1'b1;
          push_st = last_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (drop) begin
      base_d = wrap((CW + 1)'(base_q) + drop_n);
      c_d = '0;
      hs_d = 1'b0;
      total_d = '0;
      crc_d = '0;
    end
    if (go_next) begin
      replay_d = nr;
      state_d = (nr != '0) ? S_RD : S_FIN;
    end
    if (push) begin
      ov_d = 1'b1;
      ost_d = 3'(push_st);
      obyte_d = push_byte;
      obv_d = push_v;
      obl_d = push_l;
      emitted_d = 1'b1;
    end
  end

  assign rx_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ov_q;
  assign status_o     = ost_q;
  assign body_byte_o  = obyte_q;
  assign body_valid_o = obv_q;
  assign body_last_o  = obl_q;

endmodule

[design/fprc_checker.sv]
`timescale 1ns / 1ps
`include "framed_packet_receiver_crc16_top_defines.svh"
module fprc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rx_valid_i,
  input logic       rx_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [7:0] body_byte_o,
  input logic       body_valid_o,
  input logic       body_last_o
);
  import fprc_pkg::*;

  `FPRC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(body_byte_o), "Stalled result transaction changed.")
  `FPRC_ASSERT(a_one_item, rx_valid_i && !rx_stall_o |=> rx_stall_o, "Second byte taken while one is in progress.")
  `FPRC_ASSERT(a_body_ok, out_valid_o && body_valid_o |-> status_o == 3'(ST_OK), "Body byte without packet ok status.")
  `FPRC_ASSERT(a_last_body, out_valid_o && body_last_o |-> body_valid_o, "Last flag on a result without a body byte.")
  `FPRC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "Result transaction offered in reset.")

endmodule

bind framed_packet_receiver_crc16_top fprc_checker u_fprc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_valid_i),
  .rx_stall_o   (rx_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .body_byte_o  (body_byte_o),
  .body_valid_o (body_valid_o),
  .body_last_o  (body_last_o)
);

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import fprc_pkg::*;

  localparam int MaxPkt = 64;

  typedef struct {
    status_e    st;
    logic [7:0] data;
    bit         vld;
    bit         lst;
  } rx_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic [7:0] body_byte_o;
  logic       body_valid_o;
  logic       body_last_o;

  framed_packet_receiver_crc16_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .rx_valid_i(rx_valid_i), .rx_stall_o(rx_stall_o), .rx_byte_i(rx_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .body_byte_o(body_byte_o),
    .body_valid_o(body_valid_o), .body_last_o(body_last_o)
  );

  logic [7:0] pending_bytes[$];
  rx_result_t expected_results[$];
  int idle_pct;
  int stall_pct;
  bit byte_taken;
  int errors;
  int results_checked;
  int packets_sent;

  // Mirror of the receiver state.
  logic [7:0]  frame_mem[MaxPkt];
  int          frame_len;
  bit          hdr_found;
  int          frame_total;
  logic [15:0] frame_crc;
  int          replay_left;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h8005) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void discard_front(int n);
    int live;
    live = frame_len + replay_left;
    if (live > MaxPkt) live = MaxPkt;
    if (n >= live) begin
      replay_left = 0;
    end else begin
      for (int i = 0; i < live - n; i++) frame_mem[i] = frame_mem[i + n];
      replay_left = live - n;
    end
    frame_len = 0;
    hdr_found = 0;
    frame_total = 0;
    frame_crc = 0;
  endfunction

  function automatic void push_result(status_e st, logic [7:0] d, bit v, bit l);
    rx_result_t r;
    r.st = st;
    r.data = d;
    r.vld = v;
    r.lst = l;
    expected_results.push_back(r);
  endfunction

  function automatic void receive_byte(logic [7:0] rx);
    int n_out;
    status_e last_st;
    int c;
    int cut;
    int live;
    logic [7:0] b;
    logic [15:0] rx_crc;
    n_out = 0;
    last_st = ST_HUNT;
    if (frame_len + replay_left >= MaxPkt) discard_front(1);
    frame_mem[frame_len + replay_left] = rx;
    replay_left++;
    while (replay_left > 0) begin
      c = frame_len;
      if (c >= MaxPkt) begin
        discard_front(MaxPkt);
        break;
      end
      b = frame_mem[c];
      replay_left--;
      if (!hdr_found) begin
        if (c < 3 && b == (c == 0 ? Hdr0 : c == 1 ? Hdr1 : Hdr2)) begin
          frame_len = c + 1;
          frame_crc = crc_byte(frame_crc, b);
          if (frame_len == 3) begin
            hdr_found = 1;
            last_st = ST_HEADER;
          end else begin
            last_st = ST_HUNT;
          end
        end else begin
          replay_left++;
          discard_front(1);
          last_st = ST_HUNT;
        end
        continue;
      end
      frame_len = c + 1;
      if (frame_len <= 5 || c + 2 < frame_total) frame_crc = crc_byte(frame_crc, b);
      if (frame_len < 5) begin
        last_st = ST_RECV;
      end else if (frame_len == 5) begin
        frame_total = {frame_mem[4], frame_mem[3]} + 5;
        if (frame_total < 7 || frame_total > MaxPkt) begin
          push_result(ST_LEN_ERR, 8'h00, 0, 0);
          n_out++;
          discard_front(1);
        end else begin
          last_st = ST_RECV;
        end
      end else if (frame_len >= frame_total) begin
        rx_crc = {frame_mem[frame_len - 1], frame_mem[frame_len - 2]};
        if (rx_crc == frame_crc) begin
          if (frame_len <= 7) begin
            push_result(ST_OK, 8'h00, 0, 0);
            n_out++;
          end else begin
            for (int i = 5; i < frame_len - 2; i++) begin
              push_result(ST_OK, frame_mem[i], 1, i + 1 == frame_len - 2);
              n_out++;
            end
          end
          discard_front(frame_len);
        end else begin
          live = frame_len + replay_left;
          cut = live;
          push_result(ST_CRC_ERR, 8'h00, 0, 0);
          n_out++;
          for (int k = 3; k + 7 <= live; k++) begin
            if (frame_mem[k] == Hdr0 && frame_mem[k + 1] == Hdr1 && frame_mem[k + 2] == Hdr2) begin
              cut = k;
              break;
            end
          end
          discard_front(cut);
        end
      end else begin
        last_st = ST_RECV;
      end
    end
    if (n_out == 0) push_result(last_st, 8'h00, 0, 0);
  endfunction

  // Queues one framed packet with a length field of len; body holds len - 2 bytes.
  task automatic queue_packet(int len, logic [7:0] body[$], bit bad_crc);
    logic [7:0] pkt[$];
    logic [15:0] crc;
    pkt = {Hdr0, Hdr1, Hdr2, len[7:0], len[15:8]};
    foreach (body[i]) pkt.push_back(body[i]);
    crc = 0;
    foreach (pkt[i]) crc = crc_byte(crc, pkt[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    pkt.push_back(crc[7:0]);
    pkt.push_back(crc[15:8]);
    foreach (pkt[i]) pending_bytes.push_back(pkt[i]);
    packets_sent++;
  endtask

  task automatic queue_random_packet(int len, bit bad_crc);
    logic [7:0] body[$];
    for (int i = 0; i < len - 2; i++) body.push_back(8'($urandom));
    queue_packet(len, body, bad_crc);
  endtask

  // Sends a header with an oversized length field and only three trailing bytes.
  task automatic queue_bad_length(int len);
    pending_bytes.push_back(Hdr0);
    pending_bytes.push_back(Hdr1);
    pending_bytes.push_back(Hdr2);
    pending_bytes.push_back(len[7:0]);
    pending_bytes.push_back(len[15:8]);
    for (int i = 0; i < 3; i++) pending_bytes.push_back(8'($urandom));
    packets_sent++;
  endtask

  // A corrupted frame whose body carries a complete good frame, so the
  // resync search finds the inner header.
  task automatic queue_nested_packet();
    logic [7:0] body[$];
    logic [7:0] inner[$];
    logic [15:0] crc;
    int inner_len;
    inner_len = $urandom_range(2, 4);
    inner = {Hdr0, Hdr1, Hdr2, 8'(inner_len), 8'h00};
    for (int i = 0; i < inner_len - 2; i++) inner.push_back(8'($urandom));
    crc = 0;
    foreach (inner[i]) crc = crc_byte(crc, inner[i]);
    inner.push_back(crc[7:0]);
    inner.push_back(crc[15:8]);
    for (int i = 0; i < $urandom_range(0, 2); i++) body.push_back(8'($urandom));
    foreach (inner[i]) body.push_back(inner[i]);
    queue_packet(body.size() + 2, body, 1);
  endtask

  task automatic drain();
    wait (pending_bytes.size() == 0 && !rx_valid_i);
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    int start;
    int r;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_items) begin
      r = $urandom_range(99);
      if (r < 55) queue_random_packet($urandom_range(2, 12), 0);
      else if (r < 60) queue_random_packet($urandom_range(13, 59), 0);
      else if (r < 72) queue_random_packet($urandom_range(2, 12), 1);
      else if (r < 78) queue_nested_packet();
      else if (r < 83) queue_random_packet($urandom_range(0, 1), 0);
      else if (r < 86) queue_bad_length($urandom_range(60, 65535));
      else if (r < 93) begin
        for (int i = 0; i < $urandom_range(1, 4); i++) pending_bytes.push_back(8'($urandom));
      end else begin
        pending_bytes.push_back(Hdr0);
        if ($urandom_range(1)) pending_bytes.push_back(Hdr1);
        pending_bytes.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_taken <= 0;
    end else begin
      byte_taken <= rx_valid_i && !rx_stall_o;
      if (rx_valid_i && !rx_stall_o) receive_byte(rx_byte_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!rx_valid_i || byte_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          rx_valid_i <= 1;
          rx_byte_i <= pending_bytes.pop_front();
        end else begin
          rx_valid_i <= 0;
          rx_byte_i <= 8'($urandom);
        end
      end
      out_stall_i <= $urandom_range(99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    rx_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, status %0d", status_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status_o);
          errors++;
        end
        if (body_byte_o !== exp_r.data) begin
          $error("body_byte: expected %0h, got %0h", exp_r.data, body_byte_o);
          errors++;
        end
        if (body_valid_o !== exp_r.vld) begin
          $error("body_valid: expected %0d, got %0d", exp_r.vld, body_valid_o);
          errors++;
        end
        if (body_last_o !== exp_r.lst) begin
          $error("body_last: expected %0d, got %0d", exp_r.lst, body_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [7:0] body[$];
    errors = 0;
    results_checked = 0;
    packets_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    frame_len = 0;
    hdr_found = 0;
    frame_total = 0;
    frame_crc = 0;
    replay_left = 0;
    rx_valid_i = 0;
    rx_byte_i = 0;
    out_stall_i = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    pending_bytes.push_back(8'h55);
    pending_bytes.push_back(Hdr0);
    queue_random_packet(2, 0);
    body = {8'h00, 8'hFF};
    queue_packet(4, body, 0);
    queue_random_packet(0, 0);
    queue_random_packet(1, 0);
    queue_random_packet(60, 0);
    queue_bad_length(16'hFFFF);
    queue_random_packet(3, 1);
    drain();
    queue_nested_packet();
    queue_random_packet(59, 0);
    drain();

    idle_pct = 0;  stall_pct = 0;  random_phase(45); drain();
    idle_pct = 88; stall_pct = 0;  random_phase(45); drain();
    idle_pct = 0;  stall_pct = 88; random_phase(45); drain();
    idle_pct = 14; stall_pct = 14; random_phase(45); drain();

    repeat (200) @(posedge clk_i);
    $display("Sent %0d framed packets plus noise across four idle and stall mixes.",
             packets_sent);
    $display("Checked %0d result transactions, %0d mismatches.", results_checked, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/fprc_pkg.sv
design/fprc_store.sv
design/framed_packet_receiver_crc16_top.sv
design/fprc_checker.sv
test/testbench.sv
